/* design/assert_macros.svh */
// Assertion macros used by the convolution block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/cv2d_pkg.sv */
// Shared types, widths and codes for the 2D convolution block.
`timescale 1ns / 1ps

package cv2d_pkg;

  // Field and register widths
  localparam int FUNC_W     = 2;
  localparam int ADDR_W     = 14;
  localparam int DATA_W     = 16;
  localparam int OX_W       = 5;
  localparam int OY_W       = 5;
  localparam int OC_W       = 4;
  localparam int W_W        = 6;
  localparam int H_W        = 6;
  localparam int C_W        = 5;
  localparam int K_W        = 3;
  localparam int S_W        = 3;
  localparam int P_W        = 2;
  localparam int N_W        = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // Internal arithmetic widths
  localparam int CRD_W  = 10;  // signed input coordinate
  localparam int IDX_W  = 24;  // flat store index arithmetic
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;

  // Register reset values
  localparam logic [W_W-1:0] RST_IN_WIDTH    = 6'd32;
  localparam logic [H_W-1:0] RST_IN_HEIGHT   = 6'd32;
  localparam logic [C_W-1:0] RST_IN_CHANNELS = 5'd1;
  localparam logic [K_W-1:0] RST_KERNEL_SIZE = 3'd3;
  localparam logic [S_W-1:0] RST_STRIDE      = 3'd1;
  localparam logic [P_W-1:0] RST_PAD         = 2'd0;
  localparam logic [N_W-1:0] RST_NUM_OUTPUTS = 5'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_ACT  = 2'd0,
    FUNC_WR_WGT  = 2'd1,
    FUNC_WR_BIAS = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_CHANNELS = 3'd2,
    REG_KERNEL_SIZE = 3'd3,
    REG_STRIDE      = 3'd4,
    REG_PAD         = 3'd5,
    REG_NUM_OUTPUTS = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Effective (clamped) layer geometry
  typedef struct packed {
    logic [W_W-1:0] w;
    logic [H_W-1:0] h;
    logic [C_W-1:0] c;
    logic [K_W-1:0] k;
    logic [S_W-1:0] s;
    logic [P_W-1:0] p;
    logic [N_W-1:0] n;
  } cfg_t;

  // Requested output pixel
  typedef struct packed {
    logic [OX_W-1:0] ox;
    logic [OY_W-1:0] oy;
    logic [OC_W-1:0] oc;
  } req_t;

  // Commands from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic term_vld;
    logic bias_add;
  } mac_cmd_t;

  // Sequencer status towards the top level
  typedef struct packed {
    logic idle;
    logic done;
    logic bad;
  } seq_stat_t;

  // Clamp a register value to 1..hi
  function automatic logic [CFG_DATA_W-1:0] clamp_reg(logic [CFG_DATA_W-1:0] v,
                                                      int unsigned hi);
    logic [CFG_DATA_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = 6'd1;
    end else if (int'(v) > hi) begin
      r = CFG_DATA_W'(hi);
    end
    return r;
  endfunction

endpackage

/* design/conv2d_stride_pad_bias.sv */
// Top level of the multi-channel 2D convolution layer with stride, pad and bias.
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_      slave      tuser: func; tdata: address, value, out_x, out_y, out_channel
// out_     master     tuser: saturated, bad_request; tdata: result
// cfg_     write      cfg_index selects a register, cfg_data is the value
//
// A write item is stored when it is accepted. A compute item passes from acceptance
// through the setup states, the tap walk and the drain to the result register (a bad
// request goes from setup straight to done): the single multiplier walks every input
// channel and kernel tap in turn. in_tready is low while a request is being computed,
// and stays low in the final step while the previous result has not been taken.
// Reset is synchronous, active low; no store clearing pass is needed.

`include "assert_macros.svh"

module conv2d_stride_pad_bias #(
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_KERNEL   = 5,
  parameter int MAX_OUTPUTS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [47:0]                         in_tdata,  // address, value, out_x, out_y, out_channel, zero pad
  input  logic [cv2d_pkg::FUNC_W-1:0]         in_tuser,  // func
  // Result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cv2d_pkg::DATA_W-1:0]         out_tdata, // result
  output logic [1:0]                          out_tuser, // saturated, bad_request
  // Configuration writes
  input  logic                                cfg_wr_en,
  input  logic [cv2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cv2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ACT_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int WGT_DEPTH  = MAX_OUTPUTS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int BIAS_DEPTH = MAX_OUTPUTS;
  localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;

  // Configuration registers
  logic [cv2d_pkg::W_W-1:0] in_width_r;
  logic [cv2d_pkg::H_W-1:0] in_height_r;
  logic [cv2d_pkg::C_W-1:0] in_channels_r;
  logic [cv2d_pkg::K_W-1:0] kernel_size_r;
  logic [cv2d_pkg::S_W-1:0] stride_r;
  logic [cv2d_pkg::P_W-1:0] pad_r;
  logic [cv2d_pkg::N_W-1:0] num_outputs_r;

  cv2d_pkg::cfg_t      cfg;
  cv2d_pkg::req_t      req;
  cv2d_pkg::func_t     in_func;
  cv2d_pkg::mac_cmd_t  mac_cmd;
  cv2d_pkg::seq_stat_t seq_stat;

  logic in_acc;
  logic out_free;
  logic mac_busy;

  logic [ACT_AW-1:0]  act_raddr;
  logic [WGT_AW-1:0]  wgt_raddr;
  logic [BIAS_AW-1:0] bias_raddr;

  logic signed [cv2d_pkg::DATA_W-1:0] act_rdata;
  logic signed [cv2d_pkg::DATA_W-1:0] wgt_rdata;
  logic signed [cv2d_pkg::DATA_W-1:0] bias_rdata;
  logic [cv2d_pkg::DATA_W-1:0]        mac_result;
  logic                               mac_sat;

  logic                        out_valid_r;
  logic [cv2d_pkg::DATA_W-1:0] out_result_r;
  logic                        out_sat_r;
  logic                        out_bad_r;

  // Write configuration registers; unknown indexes do nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r    <= cv2d_pkg::RST_IN_WIDTH;
      in_height_r   <= cv2d_pkg::RST_IN_HEIGHT;
      in_channels_r <= cv2d_pkg::RST_IN_CHANNELS;
      kernel_size_r <= cv2d_pkg::RST_KERNEL_SIZE;
      stride_r      <= cv2d_pkg::RST_STRIDE;
      pad_r         <= cv2d_pkg::RST_PAD;
      num_outputs_r <= cv2d_pkg::RST_NUM_OUTPUTS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cv2d_pkg::REG_IN_WIDTH:    in_width_r    <= cfg_data[cv2d_pkg::W_W-1:0];
        cv2d_pkg::REG_IN_HEIGHT:   in_height_r   <= cfg_data[cv2d_pkg::H_W-1:0];
        cv2d_pkg::REG_IN_CHANNELS: in_channels_r <= cfg_data[cv2d_pkg::C_W-1:0];
        cv2d_pkg::REG_KERNEL_SIZE: kernel_size_r <= cfg_data[cv2d_pkg::K_W-1:0];
        cv2d_pkg::REG_STRIDE:      stride_r      <= cfg_data[cv2d_pkg::S_W-1:0];
        cv2d_pkg::REG_PAD:         pad_r         <= cfg_data[cv2d_pkg::P_W-1:0];
        cv2d_pkg::REG_NUM_OUTPUTS: num_outputs_r <= cfg_data[cv2d_pkg::N_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp geometry to the supported range; a zero stride acts as one
  always_comb begin
    cfg.w = cv2d_pkg::W_W'(cv2d_pkg::clamp_reg(in_width_r, MAX_WIDTH));
    cfg.h = cv2d_pkg::H_W'(cv2d_pkg::clamp_reg(in_height_r, MAX_HEIGHT));
    cfg.c = cv2d_pkg::C_W'(cv2d_pkg::clamp_reg({1'b0, in_channels_r}, MAX_CHANNELS));
    cfg.k = cv2d_pkg::K_W'(cv2d_pkg::clamp_reg({3'd0, kernel_size_r}, MAX_KERNEL));
    cfg.s = (stride_r == '0) ? 3'd1 : stride_r;
    cfg.p = pad_r;
    cfg.n = cv2d_pkg::N_W'(cv2d_pkg::clamp_reg({1'b0, num_outputs_r}, MAX_OUTPUTS));
  end

  // Unpack the input item
  assign in_func   = cv2d_pkg::func_t'(in_tuser);
  assign req.ox    = in_tdata[34:30];
  assign req.oy    = in_tdata[39:35];
  assign req.oc    = in_tdata[43:40];
  assign in_tready = seq_stat.idle;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  cv2d_store #(
    .ACT_DEPTH  (ACT_DEPTH),
    .WGT_DEPTH  (WGT_DEPTH),
    .BIAS_DEPTH (BIAS_DEPTH),
    .ACT_AW     (ACT_AW),
    .WGT_AW     (WGT_AW),
    .BIAS_AW    (BIAS_AW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_acc),
    .wr_func    (in_func),
    .wr_addr    (in_tdata[13:0]),
    .wr_data    (in_tdata[29:14]),
    .act_raddr  (act_raddr),
    .wgt_raddr  (wgt_raddr),
    .bias_raddr (bias_raddr),
    .act_rdata  (act_rdata),
    .wgt_rdata  (wgt_rdata),
    .bias_rdata (bias_rdata)
  );

  cv2d_seq #(
    .ACT_AW  (ACT_AW),
    .WGT_AW  (WGT_AW),
    .BIAS_AW (BIAS_AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (in_acc && (in_func == cv2d_pkg::FUNC_COMPUTE)),
    .req        (req),
    .mac_busy   (mac_busy),
    .out_free   (out_free),
    .cmd        (mac_cmd),
    .stat       (seq_stat),
    .act_raddr  (act_raddr),
    .wgt_raddr  (wgt_raddr),
    .bias_raddr (bias_raddr)
  );

  cv2d_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (mac_cmd),
    .act_rdata  (act_rdata),
    .wgt_rdata  (wgt_rdata),
    .bias_rdata (bias_rdata),
    .busy       (mac_busy),
    .result     (mac_result),
    .saturated  (mac_sat)
  );

  // Output register: load a finished item, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_stat.done) begin
      out_result_r <= seq_stat.bad ? '0 : mac_result;
      out_sat_r    <= !seq_stat.bad && mac_sat;
      out_bad_r    <= seq_stat.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_result_r;
  assign out_tuser  = {out_bad_r, out_sat_r};

  `ASSERT_IMPLIES(a_idle_mac_quiet, seq_stat.idle, !mac_busy, "products in flight while idle")
  `ASSERT_IMPLIES(a_no_overwrite, seq_stat.done, !out_valid_r || out_tready, "result overwritten")
  `ASSERT_IMPLIES(a_bias_after_drain, mac_cmd.bias_add, !mac_busy, "bias added before drain")
  `ASSERT_NEXT(a_compute_busy, in_acc && (in_func == cv2d_pkg::FUNC_COMPUTE), !seq_stat.idle, "compute item not started")

endmodule

/* design/cv2d_store.sv */
// Activation, weight and bias stores with registered read ports.
`timescale 1ns / 1ps

module cv2d_store #(
  parameter int ACT_DEPTH  = 16384,
  parameter int WGT_DEPTH  = 6400,
  parameter int BIAS_DEPTH = 16,
  parameter int ACT_AW     = 14,
  parameter int WGT_AW     = 13,
  parameter int BIAS_AW    = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  cv2d_pkg::func_t                    wr_func,
  input  logic [cv2d_pkg::ADDR_W-1:0]        wr_addr,
  input  logic [cv2d_pkg::DATA_W-1:0]        wr_data,
  input  logic [ACT_AW-1:0]                  act_raddr,
  input  logic [WGT_AW-1:0]                  wgt_raddr,
  input  logic [BIAS_AW-1:0]                 bias_raddr,
  output logic signed [cv2d_pkg::DATA_W-1:0] act_rdata,
  output logic signed [cv2d_pkg::DATA_W-1:0] wgt_rdata,
  output logic signed [cv2d_pkg::DATA_W-1:0] bias_rdata
);

  logic [cv2d_pkg::DATA_W-1:0] act_mem  [ACT_DEPTH];
  logic [cv2d_pkg::DATA_W-1:0] wgt_mem  [WGT_DEPTH];
  logic [cv2d_pkg::DATA_W-1:0] bias_mem [BIAS_DEPTH];
  logic [BIAS_DEPTH-1:0]       bias_vld_r;

  logic [cv2d_pkg::DATA_W-1:0] act_q_r;
  logic [cv2d_pkg::DATA_W-1:0] wgt_q_r;
  logic [cv2d_pkg::DATA_W-1:0] bias_q_r;
  logic                        bias_v_r;

  logic act_we;
  logic wgt_we;
  logic bias_we;

  // Drop writes that land beyond a store
  assign act_we  = wr_en && (wr_func == cv2d_pkg::FUNC_WR_ACT)
                   && (32'(wr_addr) < ACT_DEPTH);
  assign wgt_we  = wr_en && (wr_func == cv2d_pkg::FUNC_WR_WGT)
                   && (32'(wr_addr) < WGT_DEPTH);
  assign bias_we = wr_en && (wr_func == cv2d_pkg::FUNC_WR_BIAS)
                   && (32'(wr_addr) < BIAS_DEPTH);

  // Activation memory
  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[ACT_AW'(wr_addr)] <= wr_data;
    end
    act_q_r <= act_mem[act_raddr];
  end

  // Weight memory
  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[WGT_AW'(wr_addr)] <= wr_data;
    end
    wgt_q_r <= wgt_mem[wgt_raddr];
  end

  // Bias memory; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[BIAS_AW'(wr_addr)] <= wr_data;
    end
    bias_q_r <= bias_mem[bias_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_vld_r <= '0;
      bias_v_r   <= 1'b0;
    end else begin
      if (bias_we) begin
        bias_vld_r[BIAS_AW'(wr_addr)] <= 1'b1;
      end
      bias_v_r <= bias_vld_r[bias_raddr];
    end
  end

  assign act_rdata  = $signed(act_q_r);
  assign wgt_rdata  = $signed(wgt_q_r);
  assign bias_rdata = bias_v_r ? $signed(bias_q_r) : '0;

endmodule

/* design/cv2d_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation to Q8.8.
`timescale 1ns / 1ps

module cv2d_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cv2d_pkg::mac_cmd_t                 cmd,
  input  logic signed [cv2d_pkg::DATA_W-1:0] act_rdata,
  input  logic signed [cv2d_pkg::DATA_W-1:0] wgt_rdata,
  input  logic signed [cv2d_pkg::DATA_W-1:0] bias_rdata,
  output logic                               busy,
  output logic [cv2d_pkg::DATA_W-1:0]        result,
  output logic                               saturated
);

  logic                               rdv_r;
  logic                               pv_r;
  logic signed [cv2d_pkg::PROD_W-1:0] prod_r;
  logic [cv2d_pkg::ACC_W-1:0]         acc_r;

  logic [cv2d_pkg::ACC_W:0]   rnd;
  logic [cv2d_pkg::ACC_W-8:0] q;
  logic                       sat_hi;
  logic                       sat_lo;

  // Track operands in flight: store read, then product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
      pv_r  <= 1'b0;
    end else begin
      rdv_r <= cmd.term_vld;
      pv_r  <= rdv_r;
    end
  end

  // Register the product before it meets the accumulator
  always_ff @(posedge clk) begin
    prod_r <= act_rdata * wgt_rdata;
  end

  // Accumulate modulo 2^48; the bias enters as bias*256
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + {{(cv2d_pkg::ACC_W-cv2d_pkg::PROD_W){prod_r[cv2d_pkg::PROD_W-1]}},
                        prod_r};
    end else if (cmd.bias_add) begin
      acc_r <= acc_r + {{24{bias_rdata[cv2d_pkg::DATA_W-1]}}, bias_rdata, 8'h00};
    end
  end

  assign busy = rdv_r || pv_r;

  // Round half up, floor shift by 8, then clip to 16 bits
  assign rnd    = {acc_r[cv2d_pkg::ACC_W-1], acc_r} + 49'd128;
  assign q      = rnd[cv2d_pkg::ACC_W:8];
  assign sat_hi = !q[40] && (|q[39:15]);
  assign sat_lo = q[40] && !(&q[39:15]);

  always_comb begin
    if (sat_hi) begin
      result = 16'h7FFF;
    end else if (sat_lo) begin
      result = 16'h8000;
    end else begin
      result = q[15:0];
    end
  end

  assign saturated = sat_hi || sat_lo;

endmodule

/* design/cv2d_seq.sv */
// Sequencer: setup of one request and the walk over channels and kernel taps.
`timescale 1ns / 1ps

module cv2d_seq #(
  parameter int ACT_AW  = 14,
  parameter int WGT_AW  = 13,
  parameter int BIAS_AW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cv2d_pkg::cfg_t       cfg,
  input  logic                 start,
  input  cv2d_pkg::req_t       req,
  input  logic                 mac_busy,
  input  logic                 out_free,
  output cv2d_pkg::mac_cmd_t   cmd,
  output cv2d_pkg::seq_stat_t  stat,
  output logic [ACT_AW-1:0]    act_raddr,
  output logic [WGT_AW-1:0]    wgt_raddr,
  output logic [BIAS_AW-1:0]   bias_raddr
);

  localparam int CRD_W = cv2d_pkg::CRD_W;
  localparam int IDX_W = cv2d_pkg::IDX_W;

  cv2d_pkg::state_t state_r;
  cv2d_pkg::state_t state_nxt;

  cv2d_pkg::req_t req_r;

  logic [7:0]  oxs_r;
  logic [7:0]  oys_r;
  logic [5:0]  kk_r;
  logic [11:0] hw_r;
  logic [10:0] ckk_r;
  logic        bad_r;

  logic signed [CRD_W-1:0] ix0_r;
  logic signed [CRD_W-1:0] iy0_r;
  logic signed [IDX_W-1:0] iy0w_r;

  logic [cv2d_pkg::C_W-1:0] c_r;
  logic [cv2d_pkg::K_W-1:0] ky_r;
  logic [cv2d_pkg::K_W-1:0] kx_r;
  logic signed [CRD_W-1:0]  ix_r;
  logic signed [CRD_W-1:0]  iy_r;
  logic signed [IDX_W-1:0]  row_r;
  logic signed [IDX_W-1:0]  ch_r;
  logic [IDX_W-1:0]         widx_r;

  logic signed [CRD_W-1:0] iy0_c;
  logic signed [IDX_W-1:0] iy0_ext;
  logic signed [IDX_W-1:0] w_idx;
  logic signed [IDX_W-1:0] hw_idx;
  logic signed [IDX_W-1:0] act_sum;
  logic signed [CRD_W-1:0] w_crd;
  logic signed [CRD_W-1:0] h_crd;
  logic                    in_bounds;
  logic                    kx_last;
  logic                    ky_last;
  logic                    c_last;

  assign iy0_c   = $signed({2'b00, oys_r}) - $signed({8'd0, cfg.p});
  assign iy0_ext = IDX_W'(iy0_c);
  assign w_idx   = $signed(IDX_W'(cfg.w));
  assign hw_idx  = $signed(IDX_W'(hw_r));
  assign w_crd   = $signed({4'd0, cfg.w});
  assign h_crd   = $signed({4'd0, cfg.h});

  assign kx_last = (kx_r == cfg.k - 3'd1);
  assign ky_last = (ky_r == cfg.k - 3'd1);
  assign c_last  = (c_r == cfg.c - 5'd1);

  // Skip taps that fall in the zero border
  assign in_bounds = (ix_r >= 0) && (ix_r < w_crd) && (iy_r >= 0) && (iy_r < h_crd);
  assign act_sum   = row_r + IDX_W'(ix_r);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cv2d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cv2d_pkg::ST_IDLE: begin
        if (start) state_nxt = cv2d_pkg::ST_SETUP1;
      end
      cv2d_pkg::ST_SETUP1: state_nxt = cv2d_pkg::ST_SETUP2;
      cv2d_pkg::ST_SETUP2: state_nxt = cv2d_pkg::ST_SETUP3;
      cv2d_pkg::ST_SETUP3: begin
        state_nxt = bad_r ? cv2d_pkg::ST_DONE : cv2d_pkg::ST_RUN;
      end
      cv2d_pkg::ST_RUN: begin
        if (kx_last && ky_last && c_last) state_nxt = cv2d_pkg::ST_DRAIN;
      end
      cv2d_pkg::ST_DRAIN: begin
        if (!mac_busy) state_nxt = cv2d_pkg::ST_DONE;
      end
      cv2d_pkg::ST_DONE: begin
        if (out_free) state_nxt = cv2d_pkg::ST_IDLE;
      end
      default: state_nxt = cv2d_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.clear    = (state_r == cv2d_pkg::ST_SETUP3);
    cmd.term_vld = (state_r == cv2d_pkg::ST_RUN) && in_bounds;
    cmd.bias_add = (state_r == cv2d_pkg::ST_DRAIN) && !mac_busy;
    stat.idle    = (state_r == cv2d_pkg::ST_IDLE);
    stat.done    = (state_r == cv2d_pkg::ST_DONE) && out_free;
    stat.bad     = bad_r;
  end

  assign act_raddr  = ACT_AW'(act_sum);
  assign wgt_raddr  = WGT_AW'(widx_r);
  assign bias_raddr = BIAS_AW'(req_r.oc);

  // Setup products and the tap walk
  always_ff @(posedge clk) begin
    case (state_r)
      cv2d_pkg::ST_IDLE: begin
        if (start) req_r <= req;
      end
      cv2d_pkg::ST_SETUP1: begin
        oxs_r <= {3'd0, req_r.ox} * {5'd0, cfg.s};
        oys_r <= {3'd0, req_r.oy} * {5'd0, cfg.s};
        kk_r  <= {3'd0, cfg.k} * {3'd0, cfg.k};
        hw_r  <= {6'd0, cfg.w} * {6'd0, cfg.h};
      end
      cv2d_pkg::ST_SETUP2: begin
        ix0_r  <= $signed({2'b00, oxs_r}) - $signed({8'd0, cfg.p});
        iy0_r  <= iy0_c;
        iy0w_r <= iy0_ext * w_idx;
        ckk_r  <= {6'd0, cfg.c} * {5'd0, kk_r};
        // Output pixel lies inside iff ox*S + K <= W + 2P
        bad_r  <= ({1'b0, oxs_r} + {6'd0, cfg.k} > {3'd0, cfg.w} + {6'd0, cfg.p, 1'b0})
               || ({1'b0, oys_r} + {6'd0, cfg.k} > {3'd0, cfg.h} + {6'd0, cfg.p, 1'b0})
               || ({1'b0, req_r.oc} >= cfg.n);
      end
      cv2d_pkg::ST_SETUP3: begin
        widx_r <= IDX_W'(req_r.oc) * IDX_W'(ckk_r);
        c_r    <= '0;
        ky_r   <= '0;
        kx_r   <= '0;
        ix_r   <= ix0_r;
        iy_r   <= iy0_r;
        row_r  <= iy0w_r;
        ch_r   <= iy0w_r;
      end
      cv2d_pkg::ST_RUN: begin
        widx_r <= widx_r + IDX_W'(1);
        if (!kx_last) begin
          kx_r <= kx_r + 3'd1;
          ix_r <= ix_r + 10'sd1;
        end else begin
          kx_r <= '0;
          ix_r <= ix0_r;
          if (!ky_last) begin
            ky_r  <= ky_r + 3'd1;
            iy_r  <= iy_r + 10'sd1;
            row_r <= row_r + w_idx;
          end else begin
            // Advance to the next input channel plane
            ky_r  <= '0;
            iy_r  <= iy0_r;
            c_r   <= c_r + 5'd1;
            ch_r  <= ch_r + hw_idx;
            row_r <= ch_r + hw_idx;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
